/* design/columnar_format_string_classifier_assert.svh */
// Assertion macros for the checker in cfsc_checker.sv.
`ifndef COLUMNAR_FORMAT_STRING_CLASSIFIER_ASSERT_SVH
`define COLUMNAR_FORMAT_STRING_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define CFSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("columnar format classifier check failed");

// Next-cycle implication, off while reset is high.
`define CFSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("columnar format classifier check failed");

// Next-cycle implication that also runs across reset.
`define CFSC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("columnar format classifier check failed");

`endif

/* design/cfsc_pkg.sv */
package cfsc_pkg;

   typedef enum logic [1:0] {
      MODE_UNDECIDED,
      MODE_DECIMAL,
      MODE_WIDTH,
      MODE_OTHER
   } parse_mode_type;

   localparam logic [2:0] LAYOUT_UNSUPPORTED = 3'd0;
   localparam logic [2:0] LAYOUT_BITMAP      = 3'd1;
   localparam logic [2:0] LAYOUT_FIXED       = 3'd2;
   localparam logic [2:0] LAYOUT_VAR32       = 3'd3;
   localparam logic [2:0] LAYOUT_VAR64       = 3'd4;

   localparam int unsigned ACC_W = 34;
   localparam logic [ACC_W-1:0] NUM_LIMIT = 34'd1000000000;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_present;
      logic       last_char;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         layout_kind;
      logic signed [31:0] elem_size;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]       pos;
      logic [3:0][7:0]  lead;
      parse_mode_type   mode;
      logic [1:0]       field;
      logic [ACC_W-1:0] acc;
      logic             neg;
      logic             has_digit;
      logic             sign_ok;
      logic             reject;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '{
      pos: 3'd0, lead: '0, mode: MODE_UNDECIDED, field: 2'd0, acc: '0,
      neg: 1'b0, has_digit: 1'b0, sign_ok: 1'b1, reject: 1'b0};

endpackage

/* design/cfsc_if.sv */
interface cfsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       char_present;
   logic       last_char;

   modport source (output valid, output char_code, output char_present,
                   output last_char, input ready);
   modport sink (input valid, input char_code, input char_present,
                 input last_char, output ready);
endinterface

interface cfsc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         layout_kind;
   logic signed [31:0] elem_size;

   modport source (output valid, output layout_kind, output elem_size, input ready);
   modport sink (input valid, input layout_kind, input elem_size, output ready);
endinterface

/* design/columnar_format_string_classifier.sv */
// Channel   Role     Payload                                     Moves on
// req_ch    sink     char_code[7:0], char_present, last_char     valid && ready
// rsp_ch    source   layout_kind[2:0], elem_size[31:0] s         valid && ready
//
// One character a cycle while no last character waits: input register, parse logic,
// result register; a result is registered as its last character leaves the input stage.
// Synchronous active-high reset empties both registers and clears the parse state.
// Only a last character waits for a full result register; other characters keep flowing.
module columnar_format_string_classifier (
   input  logic       clock,
   input  logic       reset,
   cfsc_req_if.sink   req_ch,
   cfsc_rsp_if.source rsp_ch
);
   import cfsc_pkg::*;

   logic         hold_valid;
   req_item_type hold_item;
   logic         take;
   logic         out_free;
   logic         out_load;
   rsp_item_type out_item;

   cfsc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   cfsc_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (hold_valid),
      .in_item  (hold_item),
      .out_free (out_free),
      .take     (take),
      .out_load (out_load),
      .out_item (out_item)
   );

   cfsc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_item (out_item),
      .free      (out_free),
      .rsp       (rsp_ch)
   );

endmodule

/* design/cfsc_in_stage.sv */
module cfsc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   cfsc_req_if.sink              req,
   input  logic                  take,
   output logic                  hold_valid,
   output cfsc_pkg::req_item_type hold_item
);
   import cfsc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{char_code: req.char_code, char_present: req.char_present,
                      last_char: req.last_char};
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

/* design/cfsc_parser.sv */
module cfsc_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  cfsc_pkg::req_item_type in_item,
   input  logic                   out_free,
   output logic                   take,
   output logic                   out_load,
   output cfsc_pkg::rsp_item_type out_item
);
   import cfsc_pkg::*;

   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_D  = 8'h64;
   localparam logic [7:0] CH_LO_W  = 8'h77;
   localparam logic [7:0] CH_LO_T  = 8'h74;
   localparam logic [7:0] CH_LO_S  = 8'h73;
   localparam logic [7:0] CH_LO_M  = 8'h6d;
   localparam logic [7:0] CH_LO_U  = 8'h75;
   localparam logic [7:0] CH_LO_N  = 8'h6e;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_LO_C  = 8'h63;
   localparam logic [7:0] CH_UP_C  = 8'h43;
   localparam logic [7:0] CH_UP_S  = 8'h53;
   localparam logic [7:0] CH_LO_E  = 8'h65;
   localparam logic [7:0] CH_LO_I  = 8'h69;
   localparam logic [7:0] CH_UP_I  = 8'h49;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_L  = 8'h6c;
   localparam logic [7:0] CH_UP_L  = 8'h4c;
   localparam logic [7:0] CH_LO_G  = 8'h67;
   localparam logic [7:0] CH_LO_Z  = 8'h7a;
   localparam logic [7:0] CH_UP_U  = 8'h55;
   localparam logic [7:0] CH_UP_Z  = 8'h5a;

   parse_state_type st_ff;
   parse_state_type st_in;
   parse_state_type nxt;

   function automatic logic is_unit(logic [7:0] c);
      return c == CH_LO_S || c == CH_LO_M || c == CH_LO_U || c == CH_LO_N;
   endfunction

   function automatic parse_state_type feed_number(parse_state_type s, logic [7:0] ch);
      parse_state_type r;
      logic            is_digit;
      r        = s;
      is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      if (!s.reject) begin
         if (s.sign_ok && (ch == CH_PLUS || ch == CH_MINUS)) begin
            r.neg     = (ch == CH_MINUS);
            r.sign_ok = 1'b0;
         end else begin
            r.sign_ok = 1'b0;
            // refuse a non-digit, or a digit once the value is past the limit
            if (!is_digit || s.acc > NUM_LIMIT) begin
               r.reject = 1'b1;
            end else begin
               r.acc = (s.acc << 3) + (s.acc << 1) +
                       {{(ACC_W-8){1'b0}}, 8'(ch - CH_ZERO)};
               r.has_digit = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic parse_state_type decimal_comma(parse_state_type s);
      parse_state_type r;
      r = s;
      if (!s.reject) begin
         if (!s.has_digit || s.field >= 2'd2 ||
             (s.field == 2'd0 && s.neg && s.acc != '0)) begin
            r.reject = 1'b1;
         end else begin
            r.field     = s.field + 2'd1;
            r.acc       = '0;
            r.neg       = 1'b0;
            r.has_digit = 1'b0;
            r.sign_ok   = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic rsp_item_type classify(parse_state_type s);
      rsp_item_type r;
      logic         unit2;
      r.layout_kind = LAYOUT_UNSUPPORTED;
      r.elem_size   = '0;
      unit2         = is_unit(s.lead[2]);
      if (s.pos == 3'd0) begin
         r.layout_kind = LAYOUT_UNSUPPORTED;
      end else if (s.pos == 3'd1) begin
         case (s.lead[0]) inside
            CH_LO_B: r.layout_kind = LAYOUT_BITMAP;
            CH_LO_C, CH_UP_C: begin
               r.layout_kind = LAYOUT_FIXED;
               r.elem_size   = 32'sd1;
            end
            CH_LO_S, CH_UP_S, CH_LO_E: begin
               r.layout_kind = LAYOUT_FIXED;
               r.elem_size   = 32'sd2;
            end
            CH_LO_I, CH_UP_I, CH_LO_F: begin
               r.layout_kind = LAYOUT_FIXED;
               r.elem_size   = 32'sd4;
            end
            CH_LO_L, CH_UP_L, CH_LO_G: begin
               r.layout_kind = LAYOUT_FIXED;
               r.elem_size   = 32'sd8;
            end
            CH_LO_U, CH_LO_Z: r.layout_kind = LAYOUT_VAR32;
            CH_UP_U, CH_UP_Z: r.layout_kind = LAYOUT_VAR64;
            default: r.layout_kind = LAYOUT_UNSUPPORTED;
         endcase
      end else if (s.mode == MODE_DECIMAL) begin
         if (s.reject || !s.has_digit || s.field == 2'd0) begin
            r.layout_kind = LAYOUT_UNSUPPORTED;
         end else if (s.field == 2'd1) begin
            r.layout_kind = LAYOUT_FIXED;
            r.elem_size   = 32'sd16;
         end else if (s.neg && s.acc != '0) begin
            r.layout_kind = LAYOUT_UNSUPPORTED;
         end else if (s.acc == 34'd256) begin
            r.layout_kind = LAYOUT_FIXED;
            r.elem_size   = 32'sd32;
         end else if (s.acc == 34'd128) begin
            r.layout_kind = LAYOUT_FIXED;
            r.elem_size   = 32'sd16;
         end
      end else if (s.mode == MODE_WIDTH) begin
         if (!(s.reject || !s.has_digit || s.neg || s.acc == '0)) begin
            r.layout_kind = LAYOUT_FIXED;
            r.elem_size   = s.acc[31:0];
         end
      end else if (s.lead[0] == CH_LO_T) begin
         if (s.lead[1] == CH_LO_S) begin
            // timestamp: unit then colon, the zone is not checked
            if (s.pos >= 3'd4 && s.lead[3] == CH_COLON && unit2) begin
               r.layout_kind = LAYOUT_FIXED;
               r.elem_size   = 32'sd8;
            end
         end else if (s.pos == 3'd3) begin
            if (s.lead[1] == CH_LO_D) begin
               if (s.lead[2] == CH_UP_D) begin
                  r.layout_kind = LAYOUT_FIXED;
                  r.elem_size   = 32'sd4;
               end else if (s.lead[2] == CH_LO_M) begin
                  r.layout_kind = LAYOUT_FIXED;
                  r.elem_size   = 32'sd8;
               end
            end else if (s.lead[1] == CH_LO_T) begin
               if (s.lead[2] == CH_LO_S || s.lead[2] == CH_LO_M) begin
                  r.layout_kind = LAYOUT_FIXED;
                  r.elem_size   = 32'sd4;
               end else if (s.lead[2] == CH_LO_U || s.lead[2] == CH_LO_N) begin
                  r.layout_kind = LAYOUT_FIXED;
                  r.elem_size   = 32'sd8;
               end
            end else if (s.lead[1] == CH_UP_D && unit2) begin
               r.layout_kind = LAYOUT_FIXED;
               r.elem_size   = 32'sd8;
            end
         end
      end
      return r;
   endfunction

   // the final character waits while the result register is still full
   assign take     = in_valid && (!in_item.last_char || out_free);
   assign out_load = take && in_item.last_char;

   always_comb begin
      nxt = st_ff;
      if (take && in_item.char_present) begin
         if (!st_ff.pos[2]) begin
            nxt.lead[st_ff.pos[1:0]] = in_item.char_code;
         end
         if (st_ff.pos == 3'd1) begin
            if (in_item.char_code == CH_COLON && st_ff.lead[0] == CH_LO_D) begin
               nxt.mode = MODE_DECIMAL;
            end else if (in_item.char_code == CH_COLON && st_ff.lead[0] == CH_LO_W) begin
               nxt.mode = MODE_WIDTH;
            end else begin
               nxt.mode = MODE_OTHER;
            end
         end else if (st_ff.pos >= 3'd2) begin
            case (st_ff.mode)
               MODE_DECIMAL: begin
                  if (in_item.char_code == CH_COMMA) begin
                     nxt = decimal_comma(nxt);
                  end else begin
                     nxt = feed_number(nxt, in_item.char_code);
                  end
               end
               MODE_WIDTH: nxt = feed_number(nxt, in_item.char_code);
               default: ;
            endcase
         end
         if (st_ff.pos != 3'd7) begin
            nxt.pos = st_ff.pos + 3'd1;
         end
      end
      out_item = classify(nxt);
      // drop all parse state once the string ends
      st_in = out_load ? PARSE_STATE_RESET : nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= PARSE_STATE_RESET;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

/* design/cfsc_out_stage.sv */
module cfsc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  cfsc_pkg::rsp_item_type load_item,
   output logic                   free,
   cfsc_rsp_if.source             rsp
);
   import cfsc_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.layout_kind = item_ff.layout_kind;
   assign rsp.elem_size   = item_ff.elem_size;

endmodule

/* design/cfsc_checker.sv */
`include "columnar_format_string_classifier_assert.svh"

module cfsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_char,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_layout_kind,
   input logic [31:0] rsp_elem_size
);

   // reset leaves no result pending and the input side open
   `CFSC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid && req_ready)

   // input backs up only behind a stalled result
   `CFSC_ASSERT_NOW(a_stall_cause, !req_ready, rsp_valid && !rsp_ready)

   // a fresh result comes from a final character that passed the input and result registers
   `CFSC_ASSERT_NOW(a_result_source, $rose(rsp_valid),
                    $past(req_valid && req_ready && req_last_char, 2))

   `CFSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_layout_kind) && $stable(rsp_elem_size))

endmodule

bind columnar_format_string_classifier cfsc_checker u_cfsc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_last_char   (req_ch.last_char),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_layout_kind (rsp_ch.layout_kind),
   .rsp_elem_size   (rsp_ch.elem_size)
);

/* tb/sv/columnar_format_string_classifier_tb.sv */
`timescale 1ns / 100ps

module columnar_format_string_classifier_tb;
   import cfsc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 360;

   typedef enum logic [1:0] {
      GAP_NONE,
      GAP_INSIDE,
      GAP_AT_END
   } absent_spot_type;

   typedef struct {
      string           text;
      absent_spot_type gap;
      bit              typed;
      rsp_item_type    want;
   } format_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cfsc_req_if req_ch ();
   cfsc_rsp_if rsp_ch ();

   columnar_format_string_classifier u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  rsp_hold_len = 0;
   int unsigned  items_sent = 0;
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;
   rsp_item_type expected_layouts[$];
   logic [7:0]   fmt_text[$];

   // Classifier shadow state
   logic [2:0]       seen_len;
   logic [7:0]       head [4];
   parse_mode_type   mode;
   logic [1:0]       dec_field;
   logic [ACC_W-1:0] mag;
   bit               mag_neg;
   bit               mag_has_digit;
   bit               sign_ok;
   bit               num_failed;

   format_row_type format_rows [26] = '{
      '{"",               GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"b",              GAP_NONE,   1'b1, '{LAYOUT_BITMAP, 0}},
      '{"c",              GAP_NONE,   1'b1, '{LAYOUT_FIXED, 1}},
      '{"S",              GAP_NONE,   1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"L",              GAP_NONE,   1'b1, '{LAYOUT_FIXED, 8}},
      '{"z",              GAP_NONE,   1'b1, '{LAYOUT_VAR32, 0}},
      '{"U",              GAP_NONE,   1'b1, '{LAYOUT_VAR64, 0}},
      '{"\377",           GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:38,10",        GAP_NONE,   1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:76,-5,256",    GAP_NONE,   1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:-0,+3,128",    GAP_NONE,   1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:-1,2",         GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:5,2,64",       GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:5,2,128,1",    GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:5,,2",         GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"d:5",            GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"w:10000000009",  GAP_NONE,   1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"w:100000000012", GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"w:-4",           GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"w:+7",           GAP_NONE,   1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"tdD",            GAP_NONE,   1'b1, '{LAYOUT_FIXED, 4}},
      '{"tsu:UTC",        GAP_NONE,   1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"ts:u",           GAP_NONE,   1'b1, '{LAYOUT_UNSUPPORTED, 0}},
      '{"ttn",            GAP_INSIDE, 1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"tDs",            GAP_AT_END, 1'b0, '{LAYOUT_UNSUPPORTED, 0}},
      '{"i",              GAP_AT_END, 1'b0, '{LAYOUT_UNSUPPORTED, 0}}
   };

   function void restart_number();
      mag = '0;
      mag_neg = 1'b0;
      mag_has_digit = 1'b0;
      sign_ok = 1'b1;
   endfunction

   function void restart_format();
      seen_len = 3'd0;
      head = '{default: 8'h00};
      mode = MODE_UNDECIDED;
      dec_field = 2'd0;
      num_failed = 1'b0;
      restart_number();
   endfunction

   function void take_digit(input logic [7:0] ch);
      if (num_failed) return;
      if (sign_ok && (ch == "+" || ch == "-")) begin
         mag_neg = (ch == "-");
         sign_ok = 1'b0;
         return;
      end
      sign_ok = 1'b0;
      // refuse a non-digit, or a digit once the value is already past the limit
      if (ch < "0" || ch > "9" || mag > NUM_LIMIT) begin
         num_failed = 1'b1;
         return;
      end
      mag = mag * 34'd10 + {26'd0, ch - 8'h30};
      mag_has_digit = 1'b1;
   endfunction

   function bit is_time_unit(input logic [7:0] c);
      return c == "s" || c == "m" || c == "u" || c == "n";
   endfunction

   function rsp_item_type fixed_layout(input int unsigned n);
      rsp_item_type r;
      r.layout_kind = LAYOUT_FIXED;
      r.elem_size = n;
      return r;
   endfunction

   function rsp_item_type format_verdict();
      rsp_item_type r;
      r.layout_kind = LAYOUT_UNSUPPORTED;
      r.elem_size = 0;
      if (seen_len == 3'd0) begin
         return r;
      end else if (seen_len == 3'd1) begin
         case (head[0])
            "b":           r.layout_kind = LAYOUT_BITMAP;
            "c", "C":      r = fixed_layout(1);
            "s", "S", "e": r = fixed_layout(2);
            "i", "I", "f": r = fixed_layout(4);
            "l", "L", "g": r = fixed_layout(8);
            "u", "z":      r.layout_kind = LAYOUT_VAR32;
            "U", "Z":      r.layout_kind = LAYOUT_VAR64;
            default:       ;
         endcase
      end else if (mode == MODE_DECIMAL) begin
         if (!num_failed && mag_has_digit && dec_field != 2'd0) begin
            if (dec_field == 2'd1)
               r = fixed_layout(16);
            else if (!(mag_neg && mag != '0)) begin
               if (mag == 256)
                  r = fixed_layout(32);
               else if (mag == 128)
                  r = fixed_layout(16);
            end
         end
      end else if (mode == MODE_WIDTH) begin
         // width keeps only its low 32 bits, sign and all
         if (!num_failed && mag_has_digit && !mag_neg && mag != '0) begin
            r.layout_kind = LAYOUT_FIXED;
            r.elem_size = mag[31:0];
         end
      end else if (head[0] == "t") begin
         if (head[1] == "s") begin
            if (seen_len >= 3'd4 && head[3] == ":" && is_time_unit(head[2]))
               r = fixed_layout(8);
         end else if (seen_len == 3'd3) begin
            if (head[1] == "d") begin
               if (head[2] == "D")
                  r = fixed_layout(4);
               else if (head[2] == "m")
                  r = fixed_layout(8);
            end else if (head[1] == "t") begin
               if (head[2] == "s" || head[2] == "m")
                  r = fixed_layout(4);
               else if (head[2] == "u" || head[2] == "n")
                  r = fixed_layout(8);
            end else if (head[1] == "D" && is_time_unit(head[2])) begin
               r = fixed_layout(8);
            end
         end
      end
      return r;
   endfunction

   function bit classify_char(input req_item_type it, output rsp_item_type res);
      logic [7:0] ch;
      ch = it.char_code;
      res = '0;
      if (it.char_present) begin
         if (seen_len < 3'd4) head[seen_len[1:0]] = ch;
         if (seen_len == 3'd1) begin
            mode = (ch == ":" && head[0] == "d") ? MODE_DECIMAL :
                   (ch == ":" && head[0] == "w") ? MODE_WIDTH : MODE_OTHER;
         end else if (seen_len >= 3'd2) begin
            if (mode == MODE_DECIMAL && ch == ",") begin
               if (!num_failed) begin
                  if (!mag_has_digit || dec_field >= 2'd2 ||
                      (dec_field == 2'd0 && mag_neg && mag != '0))
                     num_failed = 1'b1;
                  else begin
                     dec_field = dec_field + 2'd1;
                     restart_number();
                  end
               end
            end else if (mode == MODE_DECIMAL || mode == MODE_WIDTH) begin
               take_digit(ch);
            end
         end
         if (seen_len < 3'd7) seen_len = seen_len + 3'd1;
      end
      if (!it.last_char) return 1'b0;
      res = format_verdict();
      restart_format();
      return 1'b1;
   endfunction

   function void add_text(input string s);
      for (int k = 0; k < s.len(); k++) fmt_text.push_back(s[k]);
   endfunction

   function logic [7:0] pick_from(input string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   function void add_number();
      int unsigned pick;
      int unsigned n_digits;
      pick = $urandom_range(99);
      if (pick < 8)
         fmt_text.push_back("-");
      else if (pick < 14)
         fmt_text.push_back("+");
      pick = $urandom_range(99);
      n_digits = (pick < 80) ? $urandom_range(1, 4) :
                 (pick < 93) ? $urandom_range(5, 12) : 0;
      for (int k = 0; k < n_digits; k++) fmt_text.push_back(pick_from("0123456789"));
      if ($urandom_range(99) < 4) fmt_text.push_back(8'($urandom_range(255)));
   endfunction

   function void build_random_format();
      logic [7:0] second;
      int unsigned tail_len;
      fmt_text.delete();
      case ($urandom_range(9))
         0, 1: begin
            if ($urandom_range(3) == 0)
               fmt_text.push_back(8'($urandom_range(255)));
            else
               fmt_text.push_back(pick_from("bcCsSeiIflLguzUZ"));
         end
         2, 3: begin
            add_text("d:");
            add_number();
            if ($urandom_range(99) < 90) begin
               fmt_text.push_back(",");
               add_number();
            end
            if ($urandom_range(99) < 45) begin
               fmt_text.push_back(",");
               case ($urandom_range(2))
                  0:       add_text("128");
                  1:       add_text("256");
                  default: add_number();
               endcase
               if ($urandom_range(99) < 8) begin
                  fmt_text.push_back(",");
                  add_number();
               end
            end
         end
         4, 5: begin
            add_text("w:");
            add_number();
         end
         6, 7: begin
            fmt_text.push_back("t");
            second = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pick_from("sdtD");
            fmt_text.push_back(second);
            if ($urandom_range(99) < 15)
               fmt_text.push_back(8'($urandom_range(255)));
            else if (second == "d")
               fmt_text.push_back(pick_from("Dm"));
            else
               fmt_text.push_back(pick_from("smun"));
            if (second == "s") begin
               if ($urandom_range(99) < 85) fmt_text.push_back(":");
               tail_len = $urandom_range(4);
               for (int k = 0; k < tail_len; k++) fmt_text.push_back(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(99) < 10) fmt_text.push_back(8'($urandom_range(255)));
         end
         8: begin
            tail_len = $urandom_range(8);
            for (int k = 0; k < tail_len; k++) fmt_text.push_back(8'($urandom_range(255)));
         end
         default: begin
            fmt_text.push_back(pick_from("dwt"));
            tail_len = $urandom_range(6);
            for (int k = 0; k < tail_len; k++) fmt_text.push_back(pick_from("0123456789:,+-smunDd"));
         end
      endcase
   endfunction

   task automatic feed_char(input req_item_type it, input bit typed, input rsp_item_type typed_rsp);
      rsp_item_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.char_code    <= it.char_code;
      req_ch.char_present <= it.char_present;
      req_ch.last_char    <= it.last_char;
      do @(posedge clock); while (!req_ch.ready);
      if (classify_char(it, predicted))
         expected_layouts.push_back(typed ? typed_rsp : predicted);
      if (it.char_present || it.last_char) items_sent++;
   endtask

   task automatic send_format(input bit typed, input rsp_item_type typed_rsp,
                              input absent_spot_type gap, input int unsigned absent_pct);
      req_item_type it;
      int n;
      n = fmt_text.size();
      if (n == 0) begin
         it = '{char_code: 8'($urandom_range(255)), char_present: 1'b0, last_char: 1'b1};
         feed_char(it, typed, typed_rsp);
         return;
      end
      for (int k = 0; k < n; k++) begin
         if ((gap == GAP_INSIDE && k == 1) || $urandom_range(99) < absent_pct) begin
            it = '{char_code: 8'($urandom_range(255)), char_present: 1'b0, last_char: 1'b0};
            feed_char(it, typed, typed_rsp);
         end
         it = '{char_code: fmt_text[k], char_present: 1'b1,
                last_char: (k == n - 1) && gap != GAP_AT_END};
         feed_char(it, typed, typed_rsp);
      end
      if (gap == GAP_AT_END) begin
         it = '{char_code: 8'($urandom_range(255)), char_present: 1'b0, last_char: 1'b1};
         feed_char(it, typed, typed_rsp);
      end
   endtask

   // Result side: random back-pressure, plus a long hold when requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_layouts.size() == 0) begin
            $display("%0t: unexpected result: layout_kind %0d elem_size %0d",
                     $time, rsp_ch.layout_kind, rsp_ch.elem_size);
            mismatches++;
         end else begin
            want = expected_layouts.pop_front();
            if (rsp_ch.layout_kind !== want.layout_kind) begin
               $display("%0t: layout_kind expected %0d actual %0d",
                        $time, want.layout_kind, rsp_ch.layout_kind);
               mismatches++;
            end
            if (rsp_ch.elem_size !== want.elem_size) begin
               $display("%0t: elem_size expected %0d actual %0d",
                        $time, want.elem_size, rsp_ch.elem_size);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("columnar_format_string_classifier test failed");
         $finish;
      end
   end

   initial begin
      int unsigned     phase_goal;
      int unsigned     pick;
      absent_spot_type gap;
      req_ch.valid        = 1'b0;
      req_ch.char_code    = 8'h00;
      req_ch.char_present = 1'b0;
      req_ch.last_char    = 1'b0;
      restart_format();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 80;
      foreach (format_rows[r]) begin
         fmt_text.delete();
         add_text(format_rows[r].text);
         send_format(format_rows[r].typed, format_rows[r].want, format_rows[r].gap, 0);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 30; recv_idle_pct = 80; end
            1: begin send_idle_pct = 80; recv_idle_pct = 30; end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // starve the result side so the block backs up onto its input
               rsp_hold_len = 300;
            end
         endcase
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal) begin
            build_random_format();
            pick = $urandom_range(99);
            gap = (pick < 10) ? GAP_INSIDE : (pick < 18) ? GAP_AT_END : GAP_NONE;
            send_format(1'b0, '0, gap, 3);
         end
      end
      // drop valid in the step of the final transaction
      req_ch.valid <= 1'b0;

      while (expected_layouts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("columnar_format_string_classifier test passed");
      else
         $display("columnar_format_string_classifier test failed");
      $finish;
   end

endmodule
